// File: hw/rtl/sal_pkg.sv
package sal_pkg;

   // Default number of cells in the list.
   localparam int CAPACITY_DEF = 16;

   // Widths fixed by the item fields.
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;
   localparam int MASK_W  = 16;
   localparam int TOTAL_W = 5;

   // Request kinds.
   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_BAD_POS   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Control broadcast from the top level to every cell.
   typedef struct packed {
      logic                      ins_en;
      logic                      del_en;
      logic signed [VALUE_W-1:0] value;
      logic [POS_W-1:0]          position;
   } cell_ctl_type;

endpackage

// File: hw/rtl/sorted_array_list.sv
// Channel | Direction | Handshake                | Payload
// req     | in        | req_tvalid / req_tready  | tuser: req_type; tdata: value, position
// rsp     | out       | rsp_tvalid / rsp_tready  | tuser: status; tdata: mask, total, min, max
//
// One item is taken per cycle while the result register is free or being drained;
// every cell compares and shifts in the cycle the item is accepted.
// The result appears in the cycle after acceptance and holds until rsp_tready.
// Reset (synchronous, active high) empties the list and drops any pending result.
// A stalled result stalls req_tready; the cell row itself never stalls.
module sorted_array_list #(
   parameter int CAPACITY = sal_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic [39:0] req_tdata,   // [31:0] value, [35:32] position, [39:36] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic [87:0] rsp_tdata    // [15:0] match_mask, [20:16] entry_total,
                                    // [52:21] min_value, [84:53] max_value, [87:85] zero
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int VW    = sal_pkg::VALUE_W;

   logic                      accept;
   sal_pkg::op_type           op;
   logic signed [VW-1:0]      req_value;
   logic [sal_pkg::POS_W-1:0] req_position;
   sal_pkg::cell_ctl_type     ctl;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             full;
   logic             bad_pos;

   logic signed [VW-1:0] cell_value [CAPACITY];
   logic signed [VW-1:0] cell_next  [CAPACITY];
   logic [CAPACITY-1:0]  cell_ge;
   logic [CAPACITY-1:0]  cell_match;
   logic [CAPACITY-1:0]  cell_last;

   logic [sal_pkg::MASK_W-1:0] mask;
   logic signed [VW-1:0]       min_val;
   logic signed [VW-1:0]       max_val;
   sal_pkg::status_type        status;
   logic [CNT_W+4:0]           count_wide;

   logic                         rsp_valid_ff;
   sal_pkg::status_type          status_ff;
   logic [sal_pkg::MASK_W-1:0]   mask_ff;
   logic [sal_pkg::TOTAL_W-1:0]  total_ff;
   logic signed [VW-1:0]         min_ff;
   logic signed [VW-1:0]         max_ff;

   // Input unpacking and handshake.
   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign op           = sal_pkg::op_type'(req_tuser);
   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[35:32];

   // Full and bad-position checks against the current count.
   assign full    = (count_ff == CNT_W'(CAPACITY));
   assign bad_pos = ({{CNT_W{1'b0}}, req_position} >= {4'd0, count_ff});

   always_comb begin
      ctl.ins_en   = accept && (op == sal_pkg::OP_INSERT) && !full;
      ctl.del_en   = accept && (op == sal_pkg::OP_DELETE) && !bad_pos;
      ctl.value    = req_value;
      ctl.position = req_position;
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.del_en) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // The row of cells; each hands its value to both neighbors.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VW-1:0] lo_value;
      logic                 lo_ge;
      logic signed [VW-1:0] up_value;

      if (i == 0) begin : g_first
         assign lo_value = '0;
         assign lo_ge    = 1'b0;
      end else begin : g_mid
         assign lo_value = cell_value[i-1];
         assign lo_ge    = cell_ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_top
         assign up_value = '0;
      end else begin : g_below
         assign up_value = cell_value[i+1];
      end

      sal_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .count       (count_ff),
         .count_next  (count_in),
         .lower_value (lo_value),
         .lower_ge    (lo_ge),
         .upper_value (up_value),
         .value_out   (cell_value[i]),
         .ge_out      (cell_ge[i]),
         .match_out   (cell_match[i]),
         .next_value  (cell_next[i]),
         .last_next   (cell_last[i])
      );
   end

   // Search mask covers the low sixteen positions only.
   always_comb begin
      mask = '0;
      for (int i = 0; i < sal_pkg::MASK_W; i++) begin
         if (i < CAPACITY) begin
            mask[i] = (op == sal_pkg::OP_SEARCH) && cell_match[i];
         end
      end
   end

   // Minimum is the bottom cell; maximum is the one cell flagged as last.
   always_comb begin
      min_val = (count_in != '0) ? cell_next[0] : '0;
      max_val = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         max_val = max_val | (cell_last[i] ? cell_next[i] : '0);
      end
   end

   always_comb begin
      status = sal_pkg::ST_OK;
      case (op)
         sal_pkg::OP_INSERT: if (full)         status = sal_pkg::ST_FULL;
         sal_pkg::OP_DELETE: if (bad_pos)      status = sal_pkg::ST_BAD_POS;
         sal_pkg::OP_SEARCH: if (mask == '0)   status = sal_pkg::ST_NOT_FOUND;
         default:            status = sal_pkg::ST_OK;
      endcase
   end

   assign count_wide = {5'd0, count_in};

   // Count and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff <= status;
         mask_ff   <= mask;
         total_ff  <= count_wide[sal_pkg::TOTAL_W-1:0];
         min_ff    <= min_val;
         max_ff    <= max_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'd0, max_ff, min_ff, total_ff, mask_ff};

endmodule

// File: hw/rtl/sal_cell.sv
module sal_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                               clock,
   input  sal_pkg::cell_ctl_type              ctl,
   input  logic [CNT_W-1:0]                   count,
   input  logic [CNT_W-1:0]                   count_next,
   input  logic signed [sal_pkg::VALUE_W-1:0] lower_value,
   input  logic                               lower_ge,
   input  logic signed [sal_pkg::VALUE_W-1:0] upper_value,
   output logic signed [sal_pkg::VALUE_W-1:0] value_out,
   output logic                               ge_out,
   output logic                               match_out,
   output logic signed [sal_pkg::VALUE_W-1:0] next_value,
   output logic                               last_next
);

   logic signed [sal_pkg::VALUE_W-1:0] value_ff;
   logic signed [sal_pkg::VALUE_W-1:0] value_in;
   logic                               valid;
   logic                               prev_valid;

   // This cell holds an entry when its index lies below the count.
   assign valid      = (INDEX < int'(count));
   assign prev_valid = (INDEX == 0) || ((INDEX - 1) < int'(count));

   // Since entries are sorted, the greater-or-equal flags form a run up to the top.
   assign ge_out    = valid && (ctl.value <= value_ff);
   assign match_out = valid && (ctl.value == value_ff);

   // Insert shifts up from the first greater-or-equal entry; delete shifts down.
   always_comb begin
      value_in = value_ff;
      if (ctl.ins_en) begin
         if (lower_ge) begin
            value_in = lower_value;
         end else if (ge_out || (!valid && prev_valid)) begin
            value_in = ctl.value;
         end
      end else if (ctl.del_en) begin
         if (INDEX >= int'(ctl.position)) begin
            value_in = upper_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out  = value_ff;
   assign next_value = value_in;
   assign last_next  = (int'(count_next) == (INDEX + 1));

endmodule
